### hw/rtl/skc_pkg.sv
package skc_pkg;

  // Sizes of the letter stream and of the set store
  localparam int unsigned LETTER_W  = 6;
  localparam int unsigned KMER_W    = 32;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned SET_DEPTH = 1024;
  localparam int unsigned MAX_K     = 6;

  localparam int unsigned ADDR_W    = $clog2(SET_DEPTH);
  localparam int unsigned FILL_W    = $clog2(SET_DEPTH + 1);
  localparam int unsigned K_W       = $clog2(MAX_K + 1);
  localparam int unsigned WIN_IDX_W = $clog2(MAX_K);
  localparam int unsigned PRE_W     = $clog2(MAX_K + 1);
  localparam int unsigned KLEN_W    = 3;

  // Register reset values and the smallest window length
  localparam logic [CFG_W-1:0]  ALPHA_RESET = CFG_W'(36);
  localparam logic [KLEN_W-1:0] KLEN_RESET  = KLEN_W'(3);
  localparam logic [K_W-1:0]    K_MIN       = K_W'(2);

  // Sequence kind carried in the op field
  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_TARGET = 1'b1;

  // Bit positions of the error flags
  localparam int unsigned ERR_OVF = 0;
  localparam int unsigned ERR_BAD = 1;

  typedef enum logic {
    CFG_ALPHA = 1'b0,
    CFG_KLEN  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_SCAN,
    ST_FINISH
  } skc_state_e;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                op;
    logic                last;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] shared_count;
    logic               set_overflow;
    logic               bad_letter;
  } out_word_t;

  // Control from the sequencer to the k-mer accumulator
  typedef struct packed {
    logic step;
    logic first;
  } mac_ctrl_t;

endpackage

### hw/rtl/shared_kmer_counter.sv
// Shared k-mer counter. Feed the letters of a query sequence (op 0), then of a
// target sequence (op 1), marking the final letter of each with last; the final
// target letter yields one word with the number of target k-mers that occur in
// the query's k-mer set, plus overflow and bad-letter flags. Each letter shifts
// into the window; once k letters of its sequence have arrived, its k-mer is
// built one digit a cycle on a single multiply-add unit and the set (up to 1024
// distinct query k-mers) is searched linearly, one entry a cycle, through the
// single read port of the set memory, until a hit or the end of the set.
// in_stall_o is high while a letter is being processed. A finished result waits
// in the output register without blocking input, but a final target letter that
// finds the previous result still waiting there is held in the finish state,
// with input stalled, until that word is taken.
module shared_kmer_counter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  skc_pkg::in_word_t         in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output skc_pkg::out_word_t        out_word_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  skc_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [skc_pkg::CFG_W-1:0] cfg_data_i
);
  import skc_pkg::*;

  skc_state_e          state_q, state_d;
  logic [CFG_W-1:0]    alpha_q, alpha_d;
  logic [KLEN_W-1:0]   klen_q, klen_d;
  logic [LETTER_W-1:0] win_q [MAX_K];
  logic [LETTER_W-1:0] win_d [MAX_K];
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [COUNT_W-1:0]  match_q, match_d;
  logic [1:0]          err_q, err_d;
  logic [1:0]          qflags_q, qflags_d;
  logic                open_q, open_d;
  logic                op_q, op_d;
  logic                last_q, last_d;
  logic [PRE_W-1:0]    prefix_q, prefix_d;
  logic [WIN_IDX_W-1:0] dig_q, dig_d;
  logic [FILL_W-1:0]   idx_q, idx_d;
  logic                cmp_v_q, cmp_v_d;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_q, out_d;

  logic                in_acc;
  logic [K_W-1:0]      k_eff;
  logic [LEN_W-1:0]    k_len, two_k_len;
  logic                st_start, st_close;
  logic [FILL_W-1:0]   fill_a;
  logic [1:0]          err_a, qf_a;
  logic [LEN_W-1:0]    len_base, len_next;
  logic [COUNT_W:0]    merge_sum;
  logic                merge_now;
  logic [COUNT_W-1:0]  match_m;
  logic                out_free;

  mac_ctrl_t           mac_ctrl;
  logic [KMER_W-1:0]   kmer;
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [KMER_W-1:0]   ram_rdata;
  logic                hit;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Clamp the window length register to its legal range
  always_comb begin
    k_eff = K_W'(klen_q);
    if (K_W'(klen_q) < K_MIN) begin
      k_eff = K_MIN;
    end else if (K_W'(klen_q) > K_W'(MAX_K)) begin
      k_eff = K_W'(MAX_K);
    end
  end

  assign k_len     = LEN_W'(k_eff);
  assign two_k_len = LEN_W'({k_eff, 1'b0});

  // Sequence open/close bookkeeping for an incoming word
  always_comb begin
    st_start = !open_q || (op_q != in_word_i.op);
    st_close = st_start && open_q && (op_q == OP_QUERY) && (in_word_i.op == OP_TARGET);
    fill_a   = fill_q;
    err_a    = err_q;
    qf_a     = qflags_q;
    if (st_close) begin
      if (len_q < two_k_len) begin
        fill_a         = '0;
        err_a[ERR_OVF] = 1'b0;
      end
      qf_a = err_a;
    end
    if (st_start) begin
      if (in_word_i.op == OP_QUERY) begin
        fill_a = '0;
        err_a  = '0;
        qf_a   = '0;
      end else begin
        err_a = qf_a;
      end
    end
    len_base = st_start ? '0 : len_q;
    len_next = (len_base == {LEN_W{1'b1}}) ? len_base : len_base + LEN_W'(1);
  end

  // Fold held prefix matches into the count once the target reaches 2k
  assign merge_now = (op_q == OP_TARGET) && (len_q == two_k_len);
  assign merge_sum = {1'b0, match_q} + (COUNT_W+1)'(prefix_q);
  always_comb begin
    match_m = match_q;
    if (merge_now) begin
      match_m = merge_sum[COUNT_W] ? {COUNT_W{1'b1}} : merge_sum[COUNT_W-1:0];
    end
  end

  assign hit = cmp_v_q && (ram_rdata == kmer);

  // Sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    alpha_d     = alpha_q;
    klen_d      = klen_q;
    win_d       = win_q;
    fill_d      = fill_q;
    len_d       = len_q;
    match_d     = match_q;
    err_d       = err_q;
    qflags_d    = qflags_q;
    open_d      = open_q;
    op_d        = op_q;
    last_d      = last_q;
    prefix_d    = prefix_q;
    dig_d       = dig_q;
    idx_d       = idx_q;
    cmp_v_d     = cmp_v_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mac_ctrl    = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = fill_q[ADDR_W-1:0];
    ram_raddr   = idx_q[ADDR_W-1:0];

    // Drop the result word once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // Register writes
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_i)
        CFG_ALPHA: alpha_d = cfg_data_i;
        CFG_KLEN:  klen_d  = cfg_data_i[KLEN_W-1:0];
        default:   alpha_d = alpha_q;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          fill_d   = fill_a;
          qflags_d = qf_a;
          err_d    = err_a;
          if (in_word_i.letter >= alpha_q) begin
            err_d[ERR_BAD] = 1'b1;
          end
          if (st_start) begin
            open_d   = 1'b1;
            op_d     = in_word_i.op;
            match_d  = '0;
            prefix_d = '0;
          end
          // Shift the letter into the window
          for (int i = 1; i < MAX_K; i++) begin
            win_d[i] = st_start ? '0 : win_q[i-1];
          end
          win_d[0] = in_word_i.letter;
          len_d    = len_next;
          last_d   = in_word_i.last;
          if (len_next >= k_len) begin
            state_d = ST_MAC;
            dig_d   = WIN_IDX_W'(k_eff - K_W'(1));
          end else begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_MAC: begin
        // One digit per cycle, oldest letter first
        mac_ctrl.step  = 1'b1;
        mac_ctrl.first = (dig_q == WIN_IDX_W'(k_eff - K_W'(1)));
        if (dig_q == '0) begin
          state_d = ST_SCAN;
          idx_d   = '0;
          cmp_v_d = 1'b0;
        end else begin
          dig_d = dig_q - WIN_IDX_W'(1);
        end
      end

      ST_SCAN: begin
        if (hit || (idx_q >= fill_q)) begin
          cmp_v_d = 1'b0;
          state_d = ST_FINISH;
          if (op_q == OP_QUERY) begin
            if (!hit) begin
              if (fill_q < FILL_W'(SET_DEPTH)) begin
                ram_we = 1'b1;
                fill_d = fill_q + FILL_W'(1);
              end else begin
                err_d[ERR_OVF] = 1'b1;
              end
            end
          end else if (hit) begin
            if (len_q < two_k_len) begin
              prefix_d = prefix_q + PRE_W'(1);
            end else if (match_q != {COUNT_W{1'b1}}) begin
              match_d = match_q + COUNT_W'(1);
            end
          end
        end else begin
          // Issue the next set read
          ram_re  = 1'b1;
          idx_d   = idx_q + FILL_W'(1);
          cmp_v_d = 1'b1;
        end
      end

      ST_FINISH: begin
        match_d = match_m;
        if (merge_now) begin
          prefix_d = '0;
        end
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (op_q == OP_QUERY) begin
          // Close the query; a short one leaves an empty set
          if (len_q < two_k_len) begin
            fill_d         = '0;
            err_d[ERR_OVF] = 1'b0;
            qflags_d       = {err_q[ERR_BAD], 1'b0};
          end else begin
            qflags_d = err_q;
          end
          open_d  = 1'b0;
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.shared_count = (len_q < two_k_len) ? '0 : match_m;
          out_d.set_overflow = err_q[ERR_OVF];
          out_d.bad_letter   = err_q[ERR_BAD];
          open_d             = 1'b0;
          state_d            = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      alpha_q     <= ALPHA_RESET;
      klen_q      <= KLEN_RESET;
      win_q       <= '{default: '0};
      fill_q      <= '0;
      len_q       <= '0;
      match_q     <= '0;
      err_q       <= '0;
      qflags_q    <= '0;
      open_q      <= 1'b0;
      op_q        <= OP_QUERY;
      last_q      <= 1'b0;
      prefix_q    <= '0;
      dig_q       <= '0;
      idx_q       <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      alpha_q     <= alpha_d;
      klen_q      <= klen_d;
      win_q       <= win_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      match_q     <= match_d;
      err_q       <= err_d;
      qflags_q    <= qflags_d;
      open_q      <= open_d;
      op_q        <= op_d;
      last_q      <= last_d;
      prefix_q    <= prefix_d;
      dig_q       <= dig_d;
      idx_q       <= idx_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  skc_kmer_mac u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (mac_ctrl),
    .base_i  (alpha_q),
    .digit_i (win_q[dig_q]),
    .acc_o   (kmer)
  );

  skc_set_ram #(
    .DEPTH (SET_DEPTH),
    .WIDTH (KMER_W)
  ) u_set (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (kmer),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

### hw/rtl/skc_kmer_mac.sv
module skc_kmer_mac (
  input  logic                     clk_i,
  input  skc_pkg::mac_ctrl_t       ctrl_i,
  input  logic [skc_pkg::CFG_W-1:0]    base_i,
  input  logic [skc_pkg::LETTER_W-1:0] digit_i,
  output logic [skc_pkg::KMER_W-1:0]   acc_o
);
  import skc_pkg::*;

  logic [KMER_W-1:0]       acc_q, acc_d;
  logic [KMER_W+CFG_W-1:0] prod;

  // Horner step: acc * base + digit, kept modulo 2^32
  assign prod = {{CFG_W{1'b0}}, acc_q} * {{KMER_W{1'b0}}, base_i};

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.step) begin
      if (ctrl_i.first) begin
        acc_d = {{(KMER_W-LETTER_W){1'b0}}, digit_i};
      end else begin
        acc_d = prod[KMER_W-1:0] + {{(KMER_W-LETTER_W){1'b0}}, digit_i};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

### hw/rtl/skc_set_ram.sv
module skc_set_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/skc_checker.sv
module skc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input skc_pkg::in_word_t         in_word_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input skc_pkg::out_word_t        out_word_o,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input skc_pkg::cfg_idx_e         cfg_idx_i,
  input logic [skc_pkg::CFG_W-1:0] cfg_data_i
);
  import skc_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // Block stays busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // A new result only comes out of work in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

  // Register port never blocks
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("register write refused");

endmodule

bind shared_kmer_counter skc_checker u_skc_checker (.*);

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import skc_pkg::*;

  // Wait after the last count word before touching the registers
  localparam int unsigned SETTLE_CYCLES = MAX_K + SET_DEPTH + 16;
  localparam int unsigned CYCLE_LIMIT   = 10_000_000;
  localparam int unsigned HOLD_CYCLES   = 3000;
  localparam int unsigned SEG_WORDS     = 60;
  localparam int unsigned NUM_SEGS      = 8;
  localparam int unsigned BIG_QUERY     = 1040;

  // One directed stimulus row; res is used only where typed is set
  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t res;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [23] = '{
    // target with no query before it, also too short
    {6'd5,  OP_TARGET, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd6,  OP_TARGET, 1'b1, 1'b1, 16'd0, 1'b0, 1'b0},
    // query with extreme and bad letters, left open
    {6'd0,  OP_QUERY,  1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd63, OP_QUERY,  1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd35, OP_QUERY,  1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd1,  OP_QUERY,  1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd2,  OP_QUERY,  1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd3,  OP_QUERY,  1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    // target closes the query; too short, so count 0 but bad letter kept
    {6'd0,  OP_TARGET, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd63, OP_TARGET, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd35, OP_TARGET, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd1,  OP_TARGET, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd2,  OP_TARGET, 1'b1, 1'b1, 16'd0, 1'b0, 1'b1},
    // target dropped by a new query
    {6'd1,  OP_TARGET, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd2,  OP_TARGET, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    // short query empties the set
    {6'd4,  OP_QUERY,  1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd5,  OP_QUERY,  1'b1, 1'b0, 16'd0, 1'b0, 1'b0},
    // full-length target against the empty set
    {6'd4,  OP_TARGET, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd5,  OP_TARGET, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd4,  OP_TARGET, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd5,  OP_TARGET, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd4,  OP_TARGET, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    {6'd5,  OP_TARGET, 1'b1, 1'b1, 16'd0, 1'b0, 1'b0}
  };

  // Register settings per random segment, extremes included
  localparam logic [CFG_W-1:0]  ALPHA_SET [NUM_SEGS] = '{6'd2, 6'd36, 6'd63, 6'd3,
                                                          6'd0, 6'd10, 6'd1, 6'd20};
  localparam logic [KLEN_W-1:0] KLEN_SET [NUM_SEGS]  = '{3'd2, 3'd6, 3'd7, 3'd1,
                                                          3'd0, 3'd5, 3'd4, 3'd3};

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_word_t           in_word_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_word_t          out_word_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  cfg_idx_e           cfg_idx_i;
  logic [CFG_W-1:0]   cfg_data_i;

  shared_kmer_counter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow state of the counter
  bit [CFG_W-1:0]    alpha_q = ALPHA_RESET;
  bit [KLEN_W-1:0]   klen_q  = KLEN_RESET;
  bit [LETTER_W-1:0] win_q [MAX_K];
  bit [KMER_W-1:0]   kset_q [SET_DEPTH];
  int unsigned       fill_q;
  int unsigned       len_q;
  int unsigned       total_q;
  int unsigned       prefix_q;
  bit [1:0]          err_q;
  bit [1:0]          qerr_q;
  bit                open_q;
  bit                op_q;

  out_word_t         pending_counts [$];
  bit [LETTER_W-1:0] query_letters [$];
  int unsigned       words_sent;
  int unsigned       errors;
  int unsigned       tx_idle_pct;
  int unsigned       rx_idle_pct;
  bit                hold_req;
  int unsigned       hold_left;
  longint unsigned   cycle_cnt;
  out_word_t         want_w;

  function automatic int unsigned eff_k();
    if (klen_q < K_MIN) return K_MIN;
    if (klen_q > MAX_K) return MAX_K;
    return klen_q;
  endfunction

  function automatic bit kmer_known(bit [KMER_W-1:0] kmer);
    for (int unsigned i = 0; i < fill_q; i++) begin
      if (kset_q[i] == kmer) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Close a query; a short one leaves no k-mers and no overflow
  function automatic void close_query();
    if (len_q < 2 * eff_k()) begin
      fill_q = 0;
      err_q[ERR_OVF] = 1'b0;
    end
    qerr_q = err_q;
    open_q = 1'b0;
  endfunction

  function automatic void open_sequence(bit op);
    if (open_q && op_q == OP_QUERY && op == OP_TARGET) close_query();
    if (op == OP_QUERY) begin
      fill_q = 0;
      err_q  = '0;
      qerr_q = '0;
    end else begin
      err_q = qerr_q;
    end
    foreach (win_q[i]) win_q[i] = '0;
    len_q    = 0;
    total_q  = 0;
    prefix_q = 0;
    open_q   = 1'b1;
    op_q     = op;
  endfunction

  // Advance the shadow state by one letter; return 1 with the count word on a final target
  function automatic bit tally_letter(in_word_t w, output out_word_t res);
    int unsigned     k;
    bit [KMER_W-1:0] kmer;
    k   = eff_k();
    res = '0;
    if (!open_q || op_q != w.op) open_sequence(w.op);
    if (w.letter >= alpha_q) err_q[ERR_BAD] = 1'b1;
    if (len_q < 65535) len_q++;
    for (int i = MAX_K - 1; i > 0; i--) win_q[i] = win_q[i-1];
    win_q[0] = w.letter;

    if (len_q >= k) begin
      kmer = '0;
      for (int unsigned i = 0; i < k; i++) begin
        kmer = kmer * KMER_W'(alpha_q) + KMER_W'(win_q[k-1-i]);
      end
      if (w.op == OP_QUERY) begin
        if (!kmer_known(kmer)) begin
          if (fill_q < SET_DEPTH) begin
            kset_q[fill_q] = kmer;
            fill_q++;
          end else begin
            err_q[ERR_OVF] = 1'b1;
          end
        end
      end else if (kmer_known(kmer)) begin
        if (len_q < 2 * k) prefix_q++;
        else if (total_q < 65535) total_q++;
      end
      // fold in hits held aside while the target was short
      if (w.op == OP_TARGET && len_q == 2 * k) begin
        total_q += prefix_q;
        if (total_q > 65535) total_q = 65535;
        prefix_q = 0;
      end
    end

    if (!w.last) return 1'b0;
    if (w.op == OP_QUERY) begin
      close_query();
      return 1'b0;
    end
    res.shared_count = (len_q < 2 * k) ? '0 : COUNT_W'(total_q);
    res.set_overflow = err_q[ERR_OVF];
    res.bad_letter   = err_q[ERR_BAD];
    open_q = 1'b0;
    return 1'b1;
  endfunction

  function automatic in_word_t mk_word(bit [LETTER_W-1:0] letter, bit op, bit last);
    in_word_t w;
    w.letter = letter;
    w.op     = op;
    w.last   = last;
    return w;
  endfunction

  // Mostly legal letters, now and then any code
  function automatic bit [LETTER_W-1:0] pick_letter();
    if (alpha_q == 0 || $urandom_range(24) == 0) return LETTER_W'($urandom_range(63));
    return LETTER_W'($urandom_range(int'(alpha_q) - 1));
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(in_word_t w, logic typed = 1'b0, out_word_t typed_res = '0);
    int unsigned gap;
    out_word_t   res;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    if (tally_letter(w, res)) begin
      if (typed) res = typed_res;
      pending_counts = {pending_counts, res};
    end
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_ALPHA) alpha_q = data;
    else klen_q = data[KLEN_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold off until every count word has come back
  task automatic wait_counts();
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk_i);
  endtask

  task automatic settle();
    wait_counts();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_query(int unsigned len, bit close);
    bit [LETTER_W-1:0] l;
    query_letters.delete();
    for (int unsigned i = 0; i < len; i++) begin
      l = pick_letter();
      query_letters = {query_letters, l};
      send_word(mk_word(l, OP_QUERY, close && i == len - 1));
    end
  endtask

  // Target letters copied in runs from the last query, with random ones mixed in
  task automatic send_target(int unsigned len, bit close);
    int unsigned       src;
    bit [LETTER_W-1:0] l;
    src = (query_letters.size() != 0) ? $urandom_range(query_letters.size() - 1) : 0;
    for (int unsigned i = 0; i < len; i++) begin
      if (query_letters.size() != 0 && $urandom_range(4) != 0)
        l = query_letters[(src + i) % query_letters.size()];
      else
        l = pick_letter();
      if (query_letters.size() != 0 && $urandom_range(15) == 0)
        src = $urandom_range(query_letters.size() - 1);
      send_word(mk_word(l, OP_TARGET, close && i == len - 1));
    end
  endtask

  task automatic send_copy(int unsigned from, int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_word(mk_word(query_letters[from + i], OP_TARGET, i == len - 1));
    end
  endtask

  task automatic run_segment(int unsigned quota);
    int unsigned first;
    int unsigned k;
    int unsigned pick;
    first = words_sent;
    k     = eff_k();
    while (words_sent - first < quota) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        repeat ($urandom_range(4, 1)) send_word(in_word_t'(8'($urandom)));
      end else if (pick < 40) begin
        if ($urandom_range(9) == 0) send_query($urandom_range(2 * k - 1, 1), $urandom_range(9) != 0);
        else send_query($urandom_range(2 * k + 20, 2 * k), $urandom_range(9) != 0);
      end else begin
        if ($urandom_range(7) == 0) send_target($urandom_range(2 * k - 1, 1), $urandom_range(11) != 0);
        else send_target($urandom_range(2 * k + 20, 2 * k), $urandom_range(11) != 0);
      end
      if ($urandom_range(29) == 0) wait_counts();
    end
    // close with a full target so the segment drains
    send_target(2 * k + $urandom_range(8), 1'b1);
  endtask

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result side: random stalls plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Compare each accepted count word with the oldest pending one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected count word, expected none, got %0d/%0b/%0b", $time,
                 out_word_o.shared_count, out_word_o.set_overflow, out_word_o.bad_letter);
        errors++;
      end else begin
        want_w = pending_counts.pop_front();
        check_field("shared_count", want_w.shared_count, out_word_o.shared_count);
        check_field("set_overflow", want_w.set_overflow, out_word_o.set_overflow);
        check_field("bad_letter", want_w.bad_letter, out_word_o.bad_letter);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d count words still pending", $time, pending_counts.size());
      $display("shared_kmer_counter test failed");
      $finish;
    end
  end

  initial begin
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_idx_i   = CFG_ALPHA;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    hold_req    = 1'b0;
    words_sent  = 0;
    errors      = 0;
    cycle_cnt   = 0;
    tx_idle_pct = 29;
    rx_idle_pct = 85;
    open_q      = 1'b0;
    op_q        = OP_QUERY;
    fill_q      = 0;
    len_q       = 0;
    total_q     = 0;
    prefix_q    = 0;
    err_q       = '0;
    qerr_q      = '0;
    foreach (win_q[i]) win_q[i] = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows at the reset register values
    foreach (DIR_TAB[r]) send_word(DIR_TAB[r].word, DIR_TAB[r].typed, DIR_TAB[r].res);
    settle();

    // Random segments, each with its own register setting and one of three idle mixes
    for (int unsigned seg = 0; seg < NUM_SEGS; seg++) begin
      if (seg < 3) begin
        tx_idle_pct = 29;
        rx_idle_pct = 85;
      end else if (seg < 6) begin
        tx_idle_pct = 85;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_reg(CFG_ALPHA, ALPHA_SET[seg]);
      write_reg(CFG_KLEN, {3'($urandom_range(7)), KLEN_SET[seg]});
      if (seg == 1 || seg == 6) hold_req = 1'b1;
      run_segment(SEG_WORDS);
      settle();
    end

    // Fill the set past its depth, then match against kept and dropped k-mers
    write_reg(CFG_ALPHA, 6'd36);
    write_reg(CFG_KLEN, {3'($urandom_range(7)), 3'd6});
    query_letters.delete();
    for (int unsigned i = 0; i < BIG_QUERY; i++) begin
      query_letters = {query_letters, LETTER_W'($urandom_range(35))};
      send_word(mk_word(query_letters[i], OP_QUERY, i == BIG_QUERY - 1));
    end
    send_copy(0, 24);
    send_copy(BIG_QUERY - 24, 24);
    settle();

    if (errors == 0) begin
      $display("shared_kmer_counter test passed");
    end else begin
      $display("shared_kmer_counter test failed");
    end
    $finish;
  end

endmodule
